[rtl/aprg_pkg.sv]
// Package: shared types and constants of the anemometer pulse-rate and gust block.
`timescale 1ns / 1ps
package aprg_pkg;

  // Field and register widths
  localparam int FACTOR_W   = 16;
  localparam int WINDOW_W   = 26;
  localparam int DEBOUNCE_W = 16;
  localparam int TIMER_W    = 32;
  localparam int COUNT_W    = 24;
  localparam int SPEED_W    = 16;
  localparam int PROD1_W    = COUNT_W + FACTOR_W;   // count * factor
  localparam int USEC_W     = 20;
  localparam int NUM_W      = PROD1_W + USEC_W;     // dividend
  localparam int DEN_W      = TIMER_W + 1;          // 2 * shortest interval
  localparam int STEP_W     = 4;                    // counts SPEED_W divider steps

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WINDOW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WIND_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_US = 2'd2;

  // Reset values of the registers
  localparam logic [FACTOR_W-1:0]   FACTOR_RST   = 16'd256;
  localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 26'd5000000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd1000;

  localparam logic [USEC_W-1:0] US_PER_S = 20'd1000000;

  // Stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // Controller to datapath commands
  typedef struct packed {
    logic tick;      // apply one tick to timers and counters
    logic mul1;      // first product
    logic mul2;      // scale by one million, load divisor
    logic div_init;  // load remainder, check saturation
    logic div_step;  // one quotient bit
    logic store;     // store quotient
    logic sel_gust;  // 1: gust quotient, 0: speed quotient
    logic emit;      // load the output register
  } aprg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic win_end;
    logic gust;
    logic out_free;
  } aprg_stat_t;

endpackage

[rtl/aprg_ctrl.sv]
// Controller: sequences tick update, shared multiply and divide, and item output.
`timescale 1ns / 1ps
module aprg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  aprg_pkg::aprg_stat_t stat,
  output aprg_pkg::aprg_cmd_t  cmd
);
  import aprg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_MUL1   = 3'd2;
  localparam logic [2:0] ST_MUL2   = 3'd3;
  localparam logic [2:0] ST_DINIT  = 3'd4;
  localparam logic [2:0] ST_DSTEP  = 3'd5;
  localparam logic [2:0] ST_STORE  = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SPEED_W - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              sel_gust_r, sel_gust_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    sel_gust_nxt = sel_gust_r;
    cmd          = '0;
    cmd.sel_gust = sel_gust_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.tick  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (stat.win_end) begin
          sel_gust_nxt = 1'b0;
          state_nxt    = ST_MUL1;
        end else if (stat.gust) begin
          sel_gust_nxt = 1'b1;
          state_nxt    = ST_MUL1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        // speed done, gust still pending
        if (!sel_gust_r && stat.gust) begin
          sel_gust_nxt = 1'b1;
          state_nxt    = ST_MUL1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      sel_gust_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      sel_gust_r <= sel_gust_nxt;
    end
  end

endmodule

[rtl/aprg_dp.sv]
// Datapath: tick timers, pulse counter, shared multiplier, serial divider, output register.
`timescale 1ns / 1ps
module aprg_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  aprg_pkg::aprg_cmd_t               cmd,
  output aprg_pkg::aprg_stat_t              stat,
  input  logic                              pulse_edge,
  input  logic                              gust_request,
  input  logic                              cfg_valid,
  input  logic [aprg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aprg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [aprg_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import aprg_pkg::*;

  // Configuration registers
  logic [FACTOR_W-1:0]   factor_r;
  logic [WINDOW_W-1:0]   window_r;
  logic [DEBOUNCE_W-1:0] debounce_r;

  // Tick state
  logic [TIMER_W-1:0]  since_edge_r, since_edge_nxt;
  logic [WINDOW_W-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [TIMER_W-1:0]  shortest_r, shortest_nxt;
  logic [SPEED_W-1:0]  last_speed_r;

  // Snapshots and flags of the item in work
  logic [COUNT_W-1:0]  cnt_snap_r;
  logic [WINDOW_W-1:0] win_snap_r;
  logic [TIMER_W-1:0]  short_snap_r;
  logic                win_end_r;
  logic                gust_r;

  // Arithmetic
  logic [PROD1_W-1:0]  prod1_r;
  logic [NUM_W-1:0]    num_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem_r;
  logic [SPEED_W-1:0]  quo_r;
  logic                sat_r;
  logic [SPEED_W-1:0]  gust_res_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // One tick: timers advance, edge handled, then window check, then gust
  logic [TIMER_W-1:0]  se_inc;
  logic [WINDOW_W-1:0] el_inc;
  logic [COUNT_W-1:0]  cnt_edge;
  logic [TIMER_W-1:0]  short_edge;
  logic                win_end;

  always_comb begin
    se_inc     = (&since_edge_r) ? since_edge_r : since_edge_r + 1'b1;
    el_inc     = (&elapsed_r) ? elapsed_r : elapsed_r + 1'b1;
    cnt_edge   = count_r;
    short_edge = shortest_r;
    since_edge_nxt = se_inc;
    if (pulse_edge) begin
      since_edge_nxt = '0;
      if (se_inc > TIMER_W'(debounce_r)) begin
        if (!(&count_r)) begin
          cnt_edge = count_r + 1'b1;
        end
        if (se_inc < shortest_r) begin
          short_edge = se_inc;
        end
      end
    end
    // elapsed is at least one here, so a zero window ends every tick
    win_end      = (el_inc >= window_r);
    count_nxt    = win_end ? '0 : cnt_edge;
    elapsed_nxt  = win_end ? '0 : el_inc;
    shortest_nxt = gust_request ? '1 : short_edge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r     <= FACTOR_RST;
      window_r     <= WINDOW_RST;
      debounce_r   <= DEBOUNCE_RST;
      since_edge_r <= '0;
      elapsed_r    <= '0;
      count_r      <= '0;
      shortest_r   <= '1;
      last_speed_r <= '0;
      win_end_r    <= 1'b0;
      gust_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // configuration writes, unknown index ignored
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WIND_FACTOR: factor_r   <= cfg_data[FACTOR_W-1:0];
          CFG_WINDOW_US:   window_r   <= cfg_data;
          CFG_DEBOUNCE_US: debounce_r <= cfg_data[DEBOUNCE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.tick) begin
        since_edge_r <= since_edge_nxt;
        elapsed_r    <= elapsed_nxt;
        count_r      <= count_nxt;
        shortest_r   <= shortest_nxt;
        win_end_r    <= win_end;
        gust_r       <= gust_request;
      end
      if (cmd.store && !cmd.sel_gust) begin
        last_speed_r <= sat_r ? '1 : quo_r;
      end
      // output slot
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Snapshots, multiplier and divider (payload, no reset)
  logic [PROD1_W-1:0]   mul_a;
  logic [DEN_W:0]       trial;
  logic                 trial_ge;
  logic [DEN_W:0]       trial_sub;

  always_comb begin
    mul_a     = cmd.sel_gust ? PROD1_W'(1) : PROD1_W'(cnt_snap_r);
    trial     = {rem_r, quo_r[SPEED_W-1]};
    trial_ge  = (trial >= {1'b0, den_r});
    trial_sub = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      cnt_snap_r   <= cnt_edge;
      win_snap_r   <= el_inc;
      short_snap_r <= short_edge;
    end
    if (cmd.mul1) begin
      prod1_r <= PROD1_W'(mul_a * factor_r);
    end
    if (cmd.mul2) begin
      num_r <= NUM_W'(prod1_r * US_PER_S);
      den_r <= cmd.sel_gust ? {short_snap_r, 1'b0} : DEN_W'(win_snap_r);
    end
    if (cmd.div_init) begin
      // quotient would not fit in 16 bits (or divisor zero)
      sat_r <= (num_r[NUM_W-1:SPEED_W] >= (NUM_W-SPEED_W)'(den_r));
      rem_r <= num_r[SPEED_W+DEN_W-1:SPEED_W];
      quo_r <= num_r[SPEED_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[SPEED_W-2:0], trial_ge};
    end
    if (cmd.store && cmd.sel_gust) begin
      gust_res_r <= sat_r ? '1 : quo_r;
    end
    if (cmd.emit) begin
      out_data_r <= {6'b0, gust_r, (gust_r ? gust_res_r : {SPEED_W{1'b0}}), win_end_r,
                     last_speed_r};
    end
  end

  assign stat.win_end  = win_end_r;
  assign stat.gust     = gust_r;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/anemometer_pulse_rate_gust.sv]
// Top level: anemometer pulse-rate meter with gust capture.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_*): one item per microsecond tick; tdata bit 0 flags a
//   falling edge of the anemometer in this tick, bit 1 requests a gust reading.
//   Result channel (out_*): exactly one item per input item: last wind speed,
//   a window-ended flag, gust speed and a gust-valid flag.
//   Configuration channel (cfg_*): index 0 wind factor, 1 window length,
//   2 debounce limit; write only while no item is in flight. Always ready.
// Sequence
//   A plain tick passes the idle, decide and emit states and loads the result
//   register in the emit state. A window end or a gust request adds a pass each
//   (two multiplies, divider load, 16 restoring-divide steps, store) through the
//   single shared multiplier and iterative divider; no new item is accepted
//   until the current item is emitted.
// Reset
//   rst_n (synchronous, active low) loads register defaults, clears timers,
//   count and speed, and sets the shortest interval to all ones.
// Stall
//   A finished item waits in the output register; the next item is already
//   accepted and worked on, and is held until the register is taken.
module anemometer_pulse_rate_gust (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] pulse_edge, [1] gust_request, [7:2] zero
  input  logic [aprg_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] wind_speed, [16] speed_updated, [32:17] gust_speed, [33] gust_valid, [39:34] zero
  output logic [aprg_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aprg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aprg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aprg_pkg::*;

  aprg_cmd_t  cmd;
  aprg_stat_t stat;

  assign cfg_ready = 1'b1;

  aprg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aprg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .pulse_edge   (in_tdata[0]),
    .gust_request (in_tdata[1]),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

  // One item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while previous item still in work");

  // Result never loaded in the cycle right after an accept
  a_no_early_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !cmd.emit)
    else $error("result emitted before tick was processed");

  // Gust speed reads zero without a request
  a_gust_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[33]) |-> (out_tdata[32:17] == '0))
    else $error("gust speed nonzero without gust valid");

  // Tick command only issued on an accepted item
  a_tick_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |-> (in_tvalid && in_tready))
    else $error("tick applied without accepted item");

endmodule
